FILE: rtl/core/ffsa_pkg.sv
`timescale 1ns / 1ps
package ffsa_pkg;

  localparam int TOTAL_SIZE_RESET = 1024;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_REFUSE  = 2'd0,
    VERDICT_EXACT   = 2'd1,
    VERDICT_SPLIT   = 2'd2,
    VERDICT_RELEASE = 2'd3
  } verdict_t;

  typedef struct packed {
    logic init;
    logic load;
    logic scan_run;
    logic decide;
    logic shift_start;
    logic shift_run;
    logic place_rem;
    logic place;
    logic rel;
    logic merge_start;
    logic merge_run;
    logic merge_flush;
    logic out_load;
  } ffsa_cmd_t;

  typedef struct packed {
    logic     cfg_wr;
    logic     scan_done;
    logic     shift_done;
    logic     merge_done;
    logic     out_free;
    verdict_t verdict;
  } ffsa_stat_t;

endpackage

FILE: rtl/core/ffsa_ctrl.sv
`timescale 1ns / 1ps
module ffsa_ctrl import ffsa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  ffsa_stat_t stat,
  input  logic       in_valid,
  output logic       in_ready,
  output ffsa_cmd_t  cmd
);

  typedef enum logic [9:0] {
    ST_INIT   = 10'b0000000001,
    ST_IDLE   = 10'b0000000010,
    ST_SCAN   = 10'b0000000100,
    ST_DECIDE = 10'b0000001000,
    ST_SHIFT  = 10'b0000010000,
    ST_REM    = 10'b0000100000,
    ST_PLACE  = 10'b0001000000,
    ST_MERGE  = 10'b0010000000,
    ST_FLUSH  = 10'b0100000000,
    ST_RESULT = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE) && !stat.cfg_wr;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      ST_INIT: begin
        cmd.init = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (stat.cfg_wr) begin
          state_nxt = ST_INIT;
        end else if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_done) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        unique case (stat.verdict)
          VERDICT_REFUSE: begin
            cmd.merge_start = 1'b1;
            state_nxt = ST_MERGE;
          end
          VERDICT_RELEASE: begin
            cmd.rel = 1'b1;
            cmd.merge_start = 1'b1;
            state_nxt = ST_MERGE;
          end
          VERDICT_EXACT: state_nxt = ST_PLACE;
          VERDICT_SPLIT: begin
            cmd.shift_start = 1'b1;
            state_nxt = ST_SHIFT;
          end
          default: state_nxt = ST_MERGE;
        endcase
      end
      ST_SHIFT: begin
        cmd.shift_run = 1'b1;
        if (stat.shift_done) state_nxt = ST_REM;
      end
      ST_REM: begin
        cmd.place_rem = 1'b1;
        state_nxt = ST_PLACE;
      end
      ST_PLACE: begin
        cmd.place = 1'b1;
        cmd.merge_start = 1'b1;
        state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        cmd.merge_run = 1'b1;
        if (stat.merge_done) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        cmd.merge_flush = 1'b1;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_INIT;
    else state_r <= state_nxt;
  end

endmodule

FILE: rtl/core/ffsa_dp.sv
`timescale 1ns / 1ps
module ffsa_dp import ffsa_pkg::*; #(
  parameter int MAX_SEGMENTS = 64,
  parameter int SIZE_BITS    = 21
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ffsa_cmd_t            cmd,
  output ffsa_stat_t           stat,
  input  logic                 in_cmd,
  input  logic [15:0]          in_owner_id,
  input  logic [SIZE_BITS-1:0] in_request_size,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_accepted,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata
);

  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);

  logic [SIZE_BITS-1:0] mem_len  [MAX_SEGMENTS];
  logic                 mem_busy [MAX_SEGMENTS];
  logic [15:0]          mem_own  [MAX_SEGMENTS];

  logic [SIZE_BITS-1:0] rd_len_r;
  logic                 rd_busy_r;
  logic [15:0]          rd_own_r;

  logic [SIZE_BITS-1:0] total_size_r, total_size_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 req_cmd_r, req_cmd_nxt;
  logic [15:0]          req_own_r, req_own_nxt;
  logic [SIZE_BITS-1:0] req_size_r, req_size_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [AW-1:0]        idx_d_r, idx_d_nxt;
  logic                 vld_r, vld_nxt;
  logic                 own_fnd_r, own_fnd_nxt;
  logic [AW-1:0]        own_idx_r, own_idx_nxt;
  logic [SIZE_BITS-1:0] own_len_r, own_len_nxt;
  logic                 fit_fnd_r, fit_fnd_nxt;
  logic [AW-1:0]        fit_idx_r, fit_idx_nxt;
  logic [SIZE_BITS-1:0] fit_len_r, fit_len_nxt;
  logic [CW-1:0]        w_r, w_nxt;
  logic                 held_v_r, held_v_nxt;
  logic [SIZE_BITS-1:0] held_len_r, held_len_nxt;
  logic                 held_busy_r, held_busy_nxt;
  logic [15:0]          held_own_r, held_own_nxt;
  logic                 ok_r, ok_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_acc_r, out_acc_nxt;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [SIZE_BITS-1:0] wlen;
  logic                 wbusy;
  logic [15:0]          wown;
  logic [AW-1:0]        raddr;
  logic                 cfg_wr;
  verdict_t             verdict;

  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : 32'(total_size_r);
  assign out_valid = out_valid_r;
  assign out_accepted = out_acc_r;

  always_comb begin
    if (req_cmd_r == CMD_RELEASE) begin
      verdict = own_fnd_r ? VERDICT_RELEASE : VERDICT_REFUSE;
    end else if (req_size_r == '0 || own_fnd_r || !fit_fnd_r) begin
      verdict = VERDICT_REFUSE;
    end else if (fit_len_r > req_size_r) begin
      verdict = (count_r >= CNT_MAX) ? VERDICT_REFUSE : VERDICT_SPLIT;
    end else begin
      verdict = VERDICT_EXACT;
    end
  end

  always_comb begin
    stat.cfg_wr     = cfg_wr;
    stat.scan_done  = !vld_r && (idx_r == count_r);
    stat.shift_done = !vld_r && (idx_r == CW'(fit_idx_r));
    stat.merge_done = !vld_r && (idx_r == count_r);
    stat.out_free   = !out_valid_r || out_ready;
    stat.verdict    = verdict;
  end

  always_comb begin
    total_size_nxt = total_size_r;
    count_nxt      = count_r;
    req_cmd_nxt    = req_cmd_r;
    req_own_nxt    = req_own_r;
    req_size_nxt   = req_size_r;
    idx_nxt        = idx_r;
    idx_d_nxt      = idx_d_r;
    vld_nxt        = 1'b0;
    own_fnd_nxt    = own_fnd_r;
    own_idx_nxt    = own_idx_r;
    own_len_nxt    = own_len_r;
    fit_fnd_nxt    = fit_fnd_r;
    fit_idx_nxt    = fit_idx_r;
    fit_len_nxt    = fit_len_r;
    w_nxt          = w_r;
    held_v_nxt     = held_v_r;
    held_len_nxt   = held_len_r;
    held_busy_nxt  = held_busy_r;
    held_own_nxt   = held_own_r;
    ok_nxt         = ok_r;
    out_valid_nxt  = out_valid_r;
    out_acc_nxt    = out_acc_r;
    we    = 1'b0;
    waddr = '0;
    wlen  = '0;
    wbusy = 1'b0;
    wown  = req_own_r;
    raddr = idx_r[AW-1:0];

    if (cfg_wr) total_size_nxt = pwdata[SIZE_BITS-1:0];
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    if (cmd.init) begin
      we        = 1'b1;
      waddr     = '0;
      wlen      = total_size_r;
      wbusy     = 1'b0;
      count_nxt = CW'(1);
    end

    if (cmd.load) begin
      req_cmd_nxt  = in_cmd;
      req_own_nxt  = in_owner_id;
      req_size_nxt = in_request_size;
      idx_nxt      = '0;
      own_fnd_nxt  = 1'b0;
      fit_fnd_nxt  = 1'b0;
    end

    if (cmd.scan_run) begin
      if (idx_r != count_r) begin
        idx_nxt   = idx_r + CW'(1);
        idx_d_nxt = idx_r[AW-1:0];
        vld_nxt   = 1'b1;
      end
      if (vld_r) begin
        if (rd_busy_r && rd_own_r == req_own_r && !own_fnd_r) begin
          own_fnd_nxt = 1'b1;
          own_idx_nxt = idx_d_r;
          own_len_nxt = rd_len_r;
        end
        if (!rd_busy_r && rd_len_r >= req_size_r && !fit_fnd_r) begin
          fit_fnd_nxt = 1'b1;
          fit_idx_nxt = idx_d_r;
          fit_len_nxt = rd_len_r;
        end
      end
    end

    if (cmd.decide) ok_nxt = (verdict != VERDICT_REFUSE);

    if (cmd.shift_start) idx_nxt = count_r - CW'(1);

    if (cmd.shift_run) begin
      // walk down, each word moves up one slot
      if (idx_r != CW'(fit_idx_r)) begin
        idx_nxt   = idx_r - CW'(1);
        idx_d_nxt = idx_r[AW-1:0];
        vld_nxt   = 1'b1;
      end
      if (vld_r) begin
        we    = 1'b1;
        waddr = idx_d_r + AW'(1);
        wlen  = rd_len_r;
        wbusy = rd_busy_r;
        wown  = rd_own_r;
      end
    end

    if (cmd.place_rem) begin
      we        = 1'b1;
      waddr     = fit_idx_r + AW'(1);
      wlen      = fit_len_r - req_size_r;
      wbusy     = 1'b0;
      count_nxt = count_r + CW'(1);
    end

    if (cmd.place) begin
      we    = 1'b1;
      waddr = fit_idx_r;
      wlen  = req_size_r;
      wbusy = 1'b1;
      wown  = req_own_r;
    end

    if (cmd.rel) begin
      we    = 1'b1;
      waddr = own_idx_r;
      wlen  = own_len_r;
      wbusy = 1'b0;
    end

    if (cmd.merge_start) begin
      idx_nxt    = '0;
      w_nxt      = '0;
      held_v_nxt = 1'b0;
    end

    if (cmd.merge_run) begin
      if (idx_r != count_r) begin
        idx_nxt   = idx_r + CW'(1);
        idx_d_nxt = idx_r[AW-1:0];
        vld_nxt   = 1'b1;
      end
      if (vld_r) begin
        if (held_v_r && !rd_busy_r && !held_busy_r) begin
          held_len_nxt = held_len_r + rd_len_r;
        end else begin
          if (held_v_r) begin
            we    = 1'b1;
            waddr = w_r[AW-1:0];
            wlen  = held_len_r;
            wbusy = held_busy_r;
            wown  = held_own_r;
            w_nxt = w_r + CW'(1);
          end
          held_v_nxt    = 1'b1;
          held_len_nxt  = rd_len_r;
          held_busy_nxt = rd_busy_r;
          held_own_nxt  = rd_own_r;
        end
      end
    end

    if (cmd.merge_flush) begin
      we        = 1'b1;
      waddr     = w_r[AW-1:0];
      wlen      = held_len_r;
      wbusy     = held_busy_r;
      wown      = held_own_r;
      count_nxt = w_r + CW'(1);
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_acc_nxt   = ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_len[waddr]  <= wlen;
      mem_busy[waddr] <= wbusy;
      mem_own[waddr]  <= wown;
    end
    rd_len_r  <= mem_len[raddr];
    rd_busy_r <= mem_busy[raddr];
    rd_own_r  <= mem_own[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_size_r <= SIZE_BITS'(TOTAL_SIZE_RESET);
      count_r      <= CW'(1);
      vld_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
    end else begin
      total_size_r <= total_size_nxt;
      count_r      <= count_nxt;
      vld_r        <= vld_nxt;
      out_valid_r  <= out_valid_nxt;
      idx_r        <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_cmd_r   <= req_cmd_nxt;
    req_own_r   <= req_own_nxt;
    req_size_r  <= req_size_nxt;
    idx_d_r     <= idx_d_nxt;
    own_fnd_r   <= own_fnd_nxt;
    own_idx_r   <= own_idx_nxt;
    own_len_r   <= own_len_nxt;
    fit_fnd_r   <= fit_fnd_nxt;
    fit_idx_r   <= fit_idx_nxt;
    fit_len_r   <= fit_len_nxt;
    w_r         <= w_nxt;
    held_v_r    <= held_v_nxt;
    held_len_r  <= held_len_nxt;
    held_busy_r <= held_busy_nxt;
    held_own_r  <= held_own_nxt;
    ok_r        <= ok_nxt;
    out_acc_r   <= out_acc_nxt;
  end

endmodule

FILE: rtl/core/first_fit_segment_allocator_core.sv
`timescale 1ns / 1ps
// first-fit segment allocator with free-segment coalescing
// input channel: in_valid/in_ready with in_cmd (0 allocate, 1 release),
//   in_owner_id and in_request_size; one request is worked on at a time
// result channel: out_valid/out_ready with out_accepted, one word per request
// config: apb-style port, total_size at address 0; a write rebuilds the table
//   as one free segment, to be done only while idle
// per request: a scan of the table, a shift of the entries above the fit on
//   a split, one or two placement writes on an accepted allocation or one
//   release write on an accepted release, then a merge pass over the new
//   count and a flush; the table has one read port and one write port
// request flow: one request at a time; the next word is taken as soon as the
//   previous result is parked in the output register
// reset: total_size returns to 1024 and the table is rebuilt
//   before in_ready rises
// receiver stall: the result holds in out_accepted; a finished request whose
//   result cannot be loaded waits until the output register frees up
module first_fit_segment_allocator_core import ffsa_pkg::*; #(
  parameter int MAX_SEGMENTS = 64,
  parameter int SIZE_BITS    = 21
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  input  logic [15:0]          in_owner_id,
  input  logic [SIZE_BITS-1:0] in_request_size,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_accepted,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  ffsa_cmd_t  cmd;
  ffsa_stat_t stat;

  assign pready = 1'b1;

  ffsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .stat     (stat),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  ffsa_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .SIZE_BITS    (SIZE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_cmd          (in_cmd),
    .in_owner_id     (in_owner_id),
    .in_request_size (in_request_size),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_accepted    (out_accepted),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata)
  );

endmodule
